// File: rtl/tfs_pkg.sv
// Package for the Tenengrad focus statistics core: widths, register indexes,
// result struct and divider state type. No dependencies.
`default_nettype none
package tfs_pkg;
    localparam int MaxLineWidth   = 4096;
    localparam int MaxFrameHeight = 4096;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 13;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WINDOW_LEFT   = 3'd2,
        REG_WINDOW_TOP    = 3'd3,
        REG_WINDOW_WIDTH  = 3'd4,
        REG_WINDOW_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [40:0] energy_sum;
        logic [31:0] intensity_sum;
        logic [23:0] pixel_count;
    } sums_t;

    typedef struct packed {
        logic [23:0] pixel_count;
        logic [40:0] energy_sum;
        logic [31:0] intensity_sum;
        logic [24:0] energy_mean_q8;
        logic [15:0] luma_mean_q8;
        logic [32:0] normalized_q16;
    } result_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_ENERGY,
        DIV_LUMA,
        DIV_SQUARE,
        DIV_NORM,
        DIV_DONE
    } div_state_t;
endpackage
`default_nettype wire

// File: rtl/tfs_if.sv
// Valid/ready channel interfaces for pixel requests and frame results.
// No dependencies.
`default_nettype none
interface tfs_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;
    modport source (output valid, pixel, frame_start, input ready);
    modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface tfs_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_count;
    logic [40:0] energy_sum;
    logic [31:0] intensity_sum;
    logic [24:0] energy_mean_q8;
    logic [15:0] luma_mean_q8;
    logic [32:0] normalized_q16;
    modport source (output valid, pixel_count, energy_sum, intensity_sum, energy_mean_q8,
                    luma_mean_q8, normalized_q16, input ready);
    modport sink (input valid, pixel_count, energy_sum, intensity_sum, energy_mean_q8,
                  luma_mean_q8, normalized_q16, output ready);
endinterface
`default_nettype wire

// File: rtl/tfs_front.sv
// Front part: raster position, line stores, gradient energy and sums.
// Emits frame sums into a small queue. Depends on tfs_pkg.
`default_nettype none
module tfs_front #(
    parameter int MAX_LINE_WIDTH   = tfs_pkg::MaxLineWidth,
    parameter int MAX_FRAME_HEIGHT = tfs_pkg::MaxFrameHeight
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           pixel,
    input  wire logic                 frame_start,
    input  wire logic [12:0]          frame_width,
    input  wire logic [12:0]          frame_height,
    input  wire logic [11:0]          window_left,
    input  wire logic [11:0]          window_top,
    input  wire logic [12:0]          window_width,
    input  wire logic [12:0]          window_height,
    output logic                      sums_valid,
    input  wire logic                 sums_ready,
    output tfs_pkg::sums_t            sums
);
    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int CW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int LW = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int PW = (CW > LW ? CW : LW) + 2;

    // The pipeline reads the stores in the accept cycle and computes in the cycle
    // after. A pixel is taken only while none is in flight, so pixels never overlap.
    logic [7:0] prev_mem [MAX_LINE_WIDTH];
    logic [7:0] old_mem  [MAX_LINE_WIDTH];

    logic [CW-1:0] col_reg, col_next;
    logic [LW-1:0] line_reg, line_next;
    logic [41:0] energy_reg, energy_next;
    logic [32:0] luma_reg, luma_next;
    logic [23:0] count_reg, count_next;
    logic        phase_reg, phase_next;
    logic [7:0]  px_reg;
    logic        inwin_reg, last_reg, wr_ok_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]  rd_left, rd_center, rd_right, rd_above, rd_prev_col;
    logic        q_full_reg;
    tfs_pkg::sums_t q_reg;

    logic [PW-1:0] w, h, x0, y0, x1, y1, colx, linex;
    logic [CW-1:0] col_eff;
    logic [LW-1:0] line_eff;
    logic accept, in_win, last_col, last_line;
    logic signed [17:0] gx, gy;
    logic [16:0] e;

    always_comb
    begin
        if (frame_width == '0) w = PW'(1);
        else if (PW'(frame_width) > PW'(MAX_LINE_WIDTH)) w = PW'(MAX_LINE_WIDTH);
        else w = PW'(frame_width);
        if (frame_height == '0) h = PW'(1);
        else if (PW'(frame_height) > PW'(MAX_FRAME_HEIGHT)) h = PW'(MAX_FRAME_HEIGHT);
        else h = PW'(frame_height);
        x0 = (window_left == '0) ? PW'(1) : PW'(window_left);
        y0 = (window_top == '0) ? PW'(1) : PW'(window_top);
        x1 = PW'(window_left) + PW'(window_width);
        y1 = PW'(window_top) + PW'(window_height);
        if (x1 > w - PW'(1)) x1 = w - PW'(1);
        if (y1 > h - PW'(1)) y1 = h - PW'(1);
        col_eff  = frame_start ? '0 : col_reg;
        line_eff = frame_start ? '0 : line_reg;
        colx  = PW'(col_eff);
        linex = PW'(line_eff);
        in_win = (linex >= PW'(1)) && (colx >= x0) && (colx < x1)
              && (linex - PW'(1) >= y0) && (linex - PW'(1) < y1);
        last_col  = colx >= w - PW'(1);
        last_line = linex >= h - PW'(1);
    end

    assign in_ready = !phase_reg && !(q_full_reg && !sums_ready);
    assign accept   = in_valid && in_ready;

    // Stage A: register the pixel and read the stores; while phase is set, write the stores back.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= pixel;
            addr_reg  <= AW'(col_eff);
            wr_ok_reg <= colx < PW'(MAX_LINE_WIDTH);
            inwin_reg <= in_win;
            last_reg  <= last_col && last_line;
            rd_left   <= old_mem[AW'(col_eff - CW'(1))];
            rd_above  <= old_mem[AW'(col_eff)];
            rd_center <= prev_mem[AW'(col_eff)];
            rd_right  <= prev_mem[AW'(col_eff + CW'(1))];
        end
        else if (phase_reg && wr_ok_reg)
        begin
            old_mem[addr_reg]  <= rd_center;
            prev_mem[addr_reg] <= px_reg;
        end
    end
    assign rd_prev_col = rd_center;

    always_comb
    begin
        // Differences are widened so that each square fits before the cast.
        gx = $signed({10'd0, rd_right}) - $signed({10'd0, rd_left});
        gy = $signed({10'd0, px_reg}) - $signed({10'd0, rd_above});
        e  = 17'(gx * gx) + 17'(gy * gy);
        col_next = col_reg;
        line_next = line_reg;
        energy_next = frame_start ? '0 : energy_reg;
        luma_next = frame_start ? '0 : luma_reg;
        count_next = frame_start ? '0 : count_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = 1'b1;
            if (last_col && last_line)
            begin
                col_next = '0;
                line_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                line_next = line_eff + LW'(1);
            end
            else
            begin
                col_next = col_eff + CW'(1);
                line_next = line_eff;
            end
        end
        else
        begin
            energy_next = energy_reg;
            luma_next = luma_reg;
            count_next = count_reg;
        end
        if (phase_reg)
        begin
            phase_next = 1'b0;
            if (inwin_reg)
            begin
                energy_next = energy_reg + 42'(e);
                luma_next = luma_reg + 33'(rd_prev_col);
                count_next = count_reg + 24'd1;
            end
            if (last_reg)
            begin
                energy_next = '0;
                luma_next = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            line_reg <= '0;
            energy_reg <= '0;
            luma_reg <= '0;
            count_reg <= '0;
            phase_reg <= 1'b0;
            q_full_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            line_reg <= line_next;
            energy_reg <= energy_next;
            luma_reg <= luma_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (phase_reg && last_reg)
                q_full_reg <= 1'b1;
            else if (sums_ready)
                q_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg && last_reg)
        begin
            q_reg.energy_sum <= 41'(energy_reg + (inwin_reg ? 42'(e) : 42'd0));
            q_reg.intensity_sum <= 32'(luma_reg + (inwin_reg ? 33'(rd_prev_col) : 33'd0));
            q_reg.pixel_count <= count_reg + (inwin_reg ? 24'd1 : 24'd0);
        end
    end

    assign sums_valid = q_full_reg;
    assign sums = q_reg;
endmodule
`default_nettype wire

// File: rtl/tfs_back.sv
// Back part: per-frame radix-2 divisions and the result register.
// Depends on tfs_pkg.
`default_nettype none
module tfs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           sums_valid,
    output logic                sums_ready,
    input  wire tfs_pkg::sums_t sums,
    output logic                res_valid,
    input  wire logic           res_ready,
    output tfs_pkg::result_t    res
);
    // One restoring divider, 64-bit dividend, 32-bit divisor, one bit a cycle.
    tfs_pkg::div_state_t st_reg, st_next;
    tfs_pkg::sums_t s_reg;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [24:0] em_reg, em_next;
    logic [15:0] lm_reg, lm_next;
    logic [32:0] nq_reg, nq_next;
    logic        out_v_reg, out_v_next;
    logic        load;
    logic [32:0] trial;
    logic        fits;

    assign sums_ready = (st_reg == tfs_pkg::DIV_IDLE);
    assign load = sums_valid && sums_ready;
    assign trial = {rem_reg[31:0], quo_reg[63]};
    assign fits = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        st_next = st_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        em_next = em_reg;
        lm_next = lm_reg;
        nq_next = nq_reg;
        out_v_next = out_v_reg;
        if (out_v_reg && res_ready) out_v_next = 1'b0;
        case (st_reg)
            tfs_pkg::DIV_IDLE:
            begin
                if (load)
                begin
                    em_next = '0;
                    lm_next = '0;
                    nq_next = '0;
                    if (sums.pixel_count == '0)
                        st_next = tfs_pkg::DIV_DONE;
                    else
                    begin
                        quo_next = {15'd0, sums.energy_sum, 8'd0};
                        rem_next = '0;
                        dvs_next = 32'(sums.pixel_count);
                        cnt_next = 7'd64;
                        st_next = tfs_pkg::DIV_ENERGY;
                    end
                end
            end
            tfs_pkg::DIV_ENERGY, tfs_pkg::DIV_LUMA, tfs_pkg::DIV_NORM:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = fits ? trial - {1'b0, dvs_reg} : trial;
                    quo_next = {quo_reg[62:0], fits};
                    cnt_next = cnt_reg - 7'd1;
                end
                else if (st_reg == tfs_pkg::DIV_ENERGY)
                begin
                    em_next = 25'(quo_reg);
                    quo_next = {24'd0, s_reg.intensity_sum, 8'd0};
                    rem_next = '0;
                    cnt_next = 7'd64;
                    st_next = tfs_pkg::DIV_LUMA;
                end
                else if (st_reg == tfs_pkg::DIV_LUMA)
                begin
                    lm_next = 16'(quo_reg);
                    st_next = (16'(quo_reg) > 16'd256) ? tfs_pkg::DIV_SQUARE
                                                       : tfs_pkg::DIV_DONE;
                end
                else
                begin
                    nq_next = 33'(quo_reg);
                    st_next = tfs_pkg::DIV_DONE;
                end
            end
            tfs_pkg::DIV_SQUARE:
            begin
                dvs_next = 32'(lm_reg) * 32'(lm_reg);
                quo_next = {15'd0, em_reg, 24'd0};
                rem_next = '0;
                cnt_next = 7'd64;
                st_next = tfs_pkg::DIV_NORM;
            end
            tfs_pkg::DIV_DONE:
            begin
                if (!out_v_reg || res_ready)
                begin
                    out_v_next = 1'b1;
                    st_next = tfs_pkg::DIV_IDLE;
                end
            end
            default: st_next = tfs_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= tfs_pkg::DIV_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) s_reg <= sums;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        em_reg <= em_next;
        lm_reg <= lm_next;
        nq_reg <= nq_next;
        if (st_reg == tfs_pkg::DIV_DONE && (!out_v_reg || res_ready))
        begin
            res.pixel_count <= s_reg.pixel_count;
            res.energy_sum <= (s_reg.pixel_count == '0) ? '0 : s_reg.energy_sum;
            res.intensity_sum <= (s_reg.pixel_count == '0) ? '0 : s_reg.intensity_sum;
            res.energy_mean_q8 <= em_reg;
            res.luma_mean_q8 <= lm_reg;
            res.normalized_q16 <= nq_reg;
        end
    end

    assign res_valid = out_v_reg;
endmodule
`default_nettype wire

// File: rtl/tenengrad_focus_statistics_core.sv
// Top level of the Tenengrad focus statistics core: configuration registers,
// front (pixels and sums) and back (divisions). Depends on tfs_pkg, tfs_if.
//
// Channel     Role    Moves
// pix_in      sink    one pixel request: pixel, frame_start
// res_out     source  one frame result request, after the frame's last pixel
// cfg         write   we, idx, data (six registers, no read-back)
//
// For each pixel the line stores are read, then the sums accumulate and the
// stores are written back before the next pixel is taken. The frame result
// comes from one shared bit-serial divider (up to three 64-step divisions)
// while the front keeps taking pixels of the next frame. Reset clears
// position, sums and valids; line stores are not cleared. Either side may
// stall on its own through the one-entry sums queue and the result register.
`default_nettype none
module tenengrad_focus_statistics_core #(
    parameter int MAX_LINE_WIDTH   = tfs_pkg::MaxLineWidth,
    parameter int MAX_FRAME_HEIGHT = tfs_pkg::MaxFrameHeight
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tfs_pixel_if.sink                           pix_in,
    tfs_result_if.source                        res_out,
    input  wire logic                           cfg_we,
    input  wire logic [tfs_pkg::CfgIdxW-1:0]    cfg_idx,
    input  wire logic [tfs_pkg::CfgDataW-1:0]   cfg_data
);
    logic [12:0] frame_width_reg, frame_height_reg, window_width_reg, window_height_reg;
    logic [11:0] window_left_reg, window_top_reg;
    logic sums_valid, sums_ready;
    tfs_pkg::sums_t sums;
    tfs_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= 13'd640;
            frame_height_reg <= 13'd480;
            window_left_reg <= '0;
            window_top_reg <= '0;
            window_width_reg <= 13'd640;
            window_height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (tfs_pkg::cfg_reg_t'(cfg_idx))
                tfs_pkg::REG_FRAME_WIDTH:   frame_width_reg <= cfg_data;
                tfs_pkg::REG_FRAME_HEIGHT:  frame_height_reg <= cfg_data;
                tfs_pkg::REG_WINDOW_LEFT:   window_left_reg <= cfg_data[11:0];
                tfs_pkg::REG_WINDOW_TOP:    window_top_reg <= cfg_data[11:0];
                tfs_pkg::REG_WINDOW_WIDTH:  window_width_reg <= cfg_data;
                tfs_pkg::REG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tfs_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
        .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pix_in.valid), .in_ready(pix_in.ready),
        .pixel(pix_in.pixel), .frame_start(pix_in.frame_start),
        .frame_width(frame_width_reg), .frame_height(frame_height_reg),
        .window_left(window_left_reg), .window_top(window_top_reg),
        .window_width(window_width_reg), .window_height(window_height_reg),
        .sums_valid(sums_valid), .sums_ready(sums_ready), .sums(sums)
    );

    tfs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .sums_valid(sums_valid), .sums_ready(sums_ready), .sums(sums),
        .res_valid(res_out.valid), .res_ready(res_out.ready), .res(res)
    );

    assign res_out.pixel_count = res.pixel_count;
    assign res_out.energy_sum = res.energy_sum;
    assign res_out.intensity_sum = res.intensity_sum;
    assign res_out.energy_mean_q8 = res.energy_mean_q8;
    assign res_out.luma_mean_q8 = res.luma_mean_q8;
    assign res_out.normalized_q16 = res.normalized_q16;
endmodule
`default_nettype wire
